// ----- sv/pngv_pkg.sv -----
// Shared types and constants for the PNG chunk stream validator.
// No dependencies; used by every other file of the block.
package pngv_pkg;

    localparam int unsigned TOTAL_W = 64;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_file;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         status;
        logic [30:0]        image_width;
        logic [30:0]        image_height;
        logic [4:0]         bit_depth;
        logic [2:0]         color_type;
        logic               interlace_mode;
        logic [TOTAL_W-1:0] total_size;
    } t_out_item;

    // Result of the parser for the byte it currently sees
    typedef struct packed {
        logic      give;
        t_out_item result;
    } t_parse_res;

    typedef enum logic [4:0] {
        PH_SIG  = 5'b00001,
        PH_IHDR = 5'b00010,
        PH_HDR  = 5'b00100,
        PH_SKIP = 5'b01000,
        PH_DONE = 5'b10000
    } t_phase;

    localparam logic [3:0] ST_OK      = 4'd0;
    localparam logic [3:0] ST_TRUNC   = 4'd1;
    localparam logic [3:0] ST_SIG     = 4'd2;
    localparam logic [3:0] ST_ILEN    = 4'd3;
    localparam logic [3:0] ST_ITAG    = 4'd4;
    localparam logic [3:0] ST_DIMS    = 4'd5;
    localparam logic [3:0] ST_DEPTH   = 4'd6;
    localparam logic [3:0] ST_COLOR   = 4'd7;
    localparam logic [3:0] ST_COMP    = 4'd8;
    localparam logic [3:0] ST_INTER   = 4'd9;
    localparam logic [3:0] ST_LETTERS = 4'd10;
    localparam logic [3:0] ST_OVF     = 4'd11;

    localparam logic [7:0] SIG_BYTES [8] = '{
        8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
    };

    localparam logic [31:0] TAG_IHDR = 32'h4948_4452;
    localparam logic [31:0] TAG_IEND = 32'h4945_4E44;
    localparam logic [31:0] IHDR_LEN = 32'd13;

    // Byte positions of the last byte of each group (*_LAST) and one past the end of each IHDR field (*_END)
    localparam logic [5:0] SIG_LAST  = 6'd7;
    localparam logic [5:0] IHDR_LAST = 6'd24;
    localparam logic [5:0] HDR_LAST  = 6'd7;
    localparam logic [5:0] LEN_END   = 6'd4;
    localparam logic [5:0] TAG_END   = 6'd8;
    localparam logic [5:0] WID_END   = 6'd12;
    localparam logic [5:0] HGT_END   = 6'd16;
    localparam logic [5:0] SMALL_END = 6'd21;

    // Signature plus IHDR chunk
    localparam int unsigned HEAD_SIZE    = 33;
    localparam int unsigned CHUNK_EXTRA  = 12;
    localparam int unsigned CRC_BYTES    = 4;

endpackage

// ----- sv/pngv_parser.sv -----
// Byte-wise PNG chunk structure parser: state, field capture and checks.
// Depends on pngv_pkg.
module pngv_parser #(
    parameter int unsigned SIZE_BITS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  pngv_pkg::t_in_item  i_item,
    output pngv_pkg::t_parse_res o_res
);

    pngv_pkg::t_phase r_phase, n_phase;
    logic [5:0]           r_cnt, n_cnt;
    logic                 r_sig_ok, n_sig_ok;
    logic [31:0]          r_hdr, n_hdr;
    logic [31:0]          r_tag, n_tag;
    logic [31:0]          r_width, n_width;
    logic [31:0]          r_height, n_height;
    logic [39:0]          r_small, n_small;
    logic [32:0]          r_skip, n_skip;
    logic [SIZE_BITS-1:0] r_acc, n_acc;

    logic [7:0]         b;
    logic               dec;
    logic [3:0]         dec_st;
    logic [3:0]         ihdr_st;
    logic [3:0]         out_st;
    logic [SIZE_BITS:0] sum;
    logic [32:0]        skip_dec;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    assign b = i_item.byte_value;

    // IHDR checks, in order of precedence
    always_comb begin
        priority if (r_hdr != pngv_pkg::IHDR_LEN) begin
            ihdr_st = pngv_pkg::ST_ILEN;
        end else if (r_tag != pngv_pkg::TAG_IHDR) begin
            ihdr_st = pngv_pkg::ST_ITAG;
        end else if (r_width[31] || r_height[31]) begin
            ihdr_st = pngv_pkg::ST_DIMS;
        end else if (!(r_small[39:32] == 8'd1 || r_small[39:32] == 8'd2 ||
                       r_small[39:32] == 8'd4 || r_small[39:32] == 8'd8 ||
                       r_small[39:32] == 8'd16)) begin
            ihdr_st = pngv_pkg::ST_DEPTH;
        end else if (!(r_small[31:24] == 8'd0 || r_small[31:24] == 8'd2 ||
                       r_small[31:24] == 8'd3 || r_small[31:24] == 8'd4 ||
                       r_small[31:24] == 8'd6)) begin
            ihdr_st = pngv_pkg::ST_COLOR;
        end else if (r_small[23:16] != 8'd0 || r_small[15:8] != 8'd0) begin
            ihdr_st = pngv_pkg::ST_COMP;
        end else if (r_small[7:0] > 8'd1) begin
            ihdr_st = pngv_pkg::ST_INTER;
        end else begin
            ihdr_st = pngv_pkg::ST_OK;
        end
    end

    // Running size plus chunk size plus framing; carry out means overflow
    assign sum = {1'b0, r_acc} + (SIZE_BITS + 1)'(r_hdr)
               + (SIZE_BITS + 1)'(pngv_pkg::CHUNK_EXTRA);
    assign skip_dec = (r_skip != 33'd0) ? r_skip - 33'd1 : r_skip;

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_sig_ok = r_sig_ok;
        n_hdr    = r_hdr;
        n_tag    = r_tag;
        n_width  = r_width;
        n_height = r_height;
        n_small  = r_small;
        n_skip   = r_skip;
        n_acc    = r_acc;
        dec      = 1'b0;
        dec_st   = pngv_pkg::ST_OK;

        unique case (r_phase)
            pngv_pkg::PH_SIG: begin
                if (b != pngv_pkg::SIG_BYTES[r_cnt[2:0]]) n_sig_ok = 1'b0;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == pngv_pkg::SIG_LAST) begin
                    n_cnt = 6'd0;
                    if (!n_sig_ok) begin
                        dec    = 1'b1;
                        dec_st = pngv_pkg::ST_SIG;
                    end else begin
                        n_phase = pngv_pkg::PH_IHDR;
                    end
                end
            end
            pngv_pkg::PH_IHDR: begin
                priority if (r_cnt < pngv_pkg::LEN_END) n_hdr = {r_hdr[23:0], b};
                else if (r_cnt < pngv_pkg::TAG_END) n_tag = {r_tag[23:0], b};
                else if (r_cnt < pngv_pkg::WID_END) n_width = {r_width[23:0], b};
                else if (r_cnt < pngv_pkg::HGT_END) n_height = {r_height[23:0], b};
                else if (r_cnt < pngv_pkg::SMALL_END) n_small = {r_small[31:0], b};
                else n_small = r_small;
                n_cnt = r_cnt + 6'd1;
                // last byte is CRC, so every checked field is already stored
                if (r_cnt == pngv_pkg::IHDR_LAST) begin
                    n_cnt = 6'd0;
                    if (ihdr_st != pngv_pkg::ST_OK) begin
                        dec    = 1'b1;
                        dec_st = ihdr_st;
                    end else begin
                        n_acc   = SIZE_BITS'(pngv_pkg::HEAD_SIZE);
                        n_phase = pngv_pkg::PH_HDR;
                    end
                end
            end
            pngv_pkg::PH_HDR: begin
                if (r_cnt < pngv_pkg::LEN_END) n_hdr = {r_hdr[23:0], b};
                else n_tag = {r_tag[23:0], b};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == pngv_pkg::HDR_LAST) begin
                    n_cnt = 6'd0;
                    if (!is_letter(n_tag[31:24]) || !is_letter(n_tag[23:16]) ||
                        !is_letter(n_tag[15:8]) || !is_letter(n_tag[7:0])) begin
                        dec    = 1'b1;
                        dec_st = pngv_pkg::ST_LETTERS;
                    end else if (sum[SIZE_BITS]) begin
                        dec    = 1'b1;
                        dec_st = pngv_pkg::ST_OVF;
                    end else begin
                        n_acc = sum[SIZE_BITS-1:0];
                        if (n_tag == pngv_pkg::TAG_IEND) begin
                            dec    = 1'b1;
                            dec_st = pngv_pkg::ST_OK;
                        end else begin
                            n_skip  = 33'(r_hdr) + 33'(pngv_pkg::CRC_BYTES);
                            n_phase = pngv_pkg::PH_SKIP;
                        end
                    end
                end
            end
            pngv_pkg::PH_SKIP: begin
                n_skip = skip_dec;
                if (skip_dec == 33'd0) n_phase = pngv_pkg::PH_HDR;
            end
            pngv_pkg::PH_DONE: begin
                n_phase = r_phase;
            end
            default: begin
                n_phase = pngv_pkg::PH_SIG;
            end
        endcase

        if (dec) n_phase = pngv_pkg::PH_DONE;

        // end of file always rearms for the next file
        if (i_item.end_of_file) begin
            n_phase  = pngv_pkg::PH_SIG;
            n_cnt    = 6'd0;
            n_sig_ok = 1'b1;
        end
    end

    assign out_st = dec ? dec_st : pngv_pkg::ST_TRUNC;

    always_comb begin
        o_res.give = dec || (i_item.end_of_file && r_phase != pngv_pkg::PH_DONE);
        o_res.result = '0;
        o_res.result.status = out_st;
        if (out_st == pngv_pkg::ST_OK) begin
            o_res.result.image_width    = r_width[30:0];
            o_res.result.image_height   = r_height[30:0];
            o_res.result.bit_depth      = r_small[36:32];
            o_res.result.color_type     = r_small[26:24];
            o_res.result.interlace_mode = r_small[0];
            o_res.result.total_size     = pngv_pkg::TOTAL_W'(n_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= pngv_pkg::PH_SIG;
            r_cnt    <= 6'd0;
            r_sig_ok <= 1'b1;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_sig_ok <= n_sig_ok;
        end
    end

    // Payload: every field is fully rewritten before it is used
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_hdr    <= n_hdr;
            r_tag    <= n_tag;
            r_width  <= n_width;
            r_height <= n_height;
            r_small  <= n_small;
            r_skip   <= n_skip;
            r_acc    <= n_acc;
        end
    end

endmodule

// ----- sv/png_chunk_stream_validator_core.sv -----
// Channel  | direction | handshake                 | payload
// in       | input     | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
// out      | output    | o_out_valid / i_out_ready | o_out_data (t_out_item)
//
// One byte per cycle sustained, unless a result waits on a stalled output. A byte
// sits in the input register while the parser works on it; its result is
// registered in the output register when that byte fires. Reset is synchronous,
// active low; no clearing pass. A stalled output blocks only a byte that would
// produce a result; other bytes keep flowing. Depends on pngv_pkg and pngv_parser.
module png_chunk_stream_validator_core #(
    parameter int unsigned SIZE_BITS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pngv_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pngv_pkg::t_out_item o_out_data
);

    logic                r_in_valid;
    pngv_pkg::t_in_item  r_in_data;
    logic                r_out_valid;
    pngv_pkg::t_out_item r_out_data;

    pngv_pkg::t_parse_res parse;
    logic                 out_free;
    logic                 fire;

    pngv_parser #(
        .SIZE_BITS(SIZE_BITS)
    ) u_parser (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_fire (fire),
        .i_item (r_in_data),
        .o_res  (parse)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && (!parse.give || out_free);
    assign o_in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) r_in_valid <= i_in_valid;
            if (fire && parse.give) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) r_in_data <= i_in_data;
        if (fire && parse.give) r_out_data <= parse.result;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- sv/pngv_checker.sv -----
// Port-level checks for the PNG chunk stream validator, bound to the top.
// Depends on pngv_pkg and png_chunk_stream_validator_core.
module pngv_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input pngv_pkg::t_out_item o_out_data
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status <= pngv_pkg::ST_OVF)
        else $error("status code out of range");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != pngv_pkg::ST_OK |->
            o_out_data.image_width == '0 && o_out_data.image_height == '0 &&
            o_out_data.bit_depth == '0 && o_out_data.total_size == '0)
        else $error("failing result carries image fields");

    // signature, IHDR and a 12-byte IEND at the least
    a_ok_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == pngv_pkg::ST_OK |->
            o_out_data.total_size >= 64'd45 && o_out_data.bit_depth != 5'd0)
        else $error("ok result with impossible size or depth");

endmodule

bind png_chunk_stream_validator_core pngv_checker u_pngv_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);

// ----- test/png_result_checker.sv -----
// Scoreboard for png_chunk_stream_validator_core: follows both channels, predicts the
// result of every file from the accepted bytes and compares it field by field.
// Depends on pngv_pkg.
module png_result_checker #(
    parameter int unsigned SIZE_BITS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  pngv_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  pngv_pkg::t_out_item i_out_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    // parser model state
    pngv_pkg::t_phase ph;
    logic [5:0]  byte_cnt;
    bit          sig_ok;
    logic [31:0] len_word;
    logic [31:0] tag_word;
    logic [31:0] wid_word;
    logic [31:0] hgt_word;
    logic [39:0] small_bytes;
    logic [32:0] skip_left;
    logic [63:0] size_acc;
    bit          decided;

    pngv_pkg::t_out_item expected_q[$];
    int          errs = 0;
    string       field_name [7] = '{"status", "image_width", "image_height", "bit_depth",
                                    "color_type", "interlace_mode", "total_size"};

    assign o_fail_count = errs;

    task automatic clear_parse();
        ph          = pngv_pkg::PH_SIG;
        byte_cnt    = '0;
        sig_ok      = 1'b1;
        len_word    = '0;
        tag_word    = '0;
        wid_word    = '0;
        hgt_word    = '0;
        small_bytes = '0;
        skip_left   = '0;
        size_acc    = '0;
        decided     = 1'b0;
    endtask

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic [3:0] ihdr_status();
        logic [7:0] depth;
        logic [7:0] color;
        depth = small_bytes[39:32];
        color = small_bytes[31:24];
        if (len_word != pngv_pkg::IHDR_LEN) return pngv_pkg::ST_ILEN;
        if (tag_word != pngv_pkg::TAG_IHDR) return pngv_pkg::ST_ITAG;
        if (wid_word[31] || hgt_word[31]) return pngv_pkg::ST_DIMS;
        if (!(depth == 1 || depth == 2 || depth == 4 || depth == 8 || depth == 16))
            return pngv_pkg::ST_DEPTH;
        if (!(color == 0 || color == 2 || color == 3 || color == 4 || color == 6))
            return pngv_pkg::ST_COLOR;
        if (small_bytes[23:16] != 0 || small_bytes[15:8] != 0) return pngv_pkg::ST_COMP;
        if (small_bytes[7:0] > 1) return pngv_pkg::ST_INTER;
        return pngv_pkg::ST_OK;
    endfunction

    task automatic close_file(input logic [3:0] st);
        pngv_pkg::t_out_item r;
        r        = '0;
        r.status = st;
        if (st == pngv_pkg::ST_OK) begin
            r.image_width    = wid_word[30:0];
            r.image_height   = hgt_word[30:0];
            r.bit_depth      = small_bytes[36:32];
            r.color_type     = small_bytes[26:24];
            r.interlace_mode = small_bytes[0];
            r.total_size     = size_acc;
        end
        expected_q.push_back(r);
        ph      = pngv_pkg::PH_DONE;
        decided = 1'b1;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic eof_bit);
        logic [63:0] maxv;
        logic [63:0] sz;
        logic [3:0]  st;
        maxv = {64{1'b1}} >> (64 - SIZE_BITS);
        case (ph)
            pngv_pkg::PH_SIG: begin
                if (b != pngv_pkg::SIG_BYTES[byte_cnt[2:0]]) sig_ok = 1'b0;
                if (byte_cnt == pngv_pkg::SIG_LAST) begin
                    byte_cnt = '0;
                    if (!sig_ok) close_file(pngv_pkg::ST_SIG);
                    else ph = pngv_pkg::PH_IHDR;
                end else begin
                    byte_cnt++;
                end
            end
            pngv_pkg::PH_IHDR: begin
                if (byte_cnt < pngv_pkg::LEN_END) len_word = {len_word[23:0], b};
                else if (byte_cnt < pngv_pkg::TAG_END) tag_word = {tag_word[23:0], b};
                else if (byte_cnt < pngv_pkg::WID_END) wid_word = {wid_word[23:0], b};
                else if (byte_cnt < pngv_pkg::HGT_END) hgt_word = {hgt_word[23:0], b};
                else if (byte_cnt < pngv_pkg::SMALL_END) small_bytes = {small_bytes[31:0], b};
                if (byte_cnt == pngv_pkg::IHDR_LAST) begin
                    byte_cnt = '0;
                    st = ihdr_status();
                    if (st != pngv_pkg::ST_OK) begin
                        close_file(st);
                    end else begin
                        size_acc = 64'(pngv_pkg::HEAD_SIZE);
                        ph       = pngv_pkg::PH_HDR;
                    end
                end else begin
                    byte_cnt++;
                end
            end
            pngv_pkg::PH_HDR: begin
                if (byte_cnt < pngv_pkg::LEN_END) len_word = {len_word[23:0], b};
                else tag_word = {tag_word[23:0], b};
                if (byte_cnt == pngv_pkg::HDR_LAST) begin
                    byte_cnt = '0;
                    sz = {32'b0, len_word};
                    if (!(is_letter(tag_word[31:24]) && is_letter(tag_word[23:16]) &&
                          is_letter(tag_word[15:8]) && is_letter(tag_word[7:0]))) begin
                        close_file(pngv_pkg::ST_LETTERS);
                    end else if (size_acc > maxv - 64'(pngv_pkg::CHUNK_EXTRA) ||
                                 sz > maxv - 64'(pngv_pkg::CHUNK_EXTRA) - size_acc) begin
                        close_file(pngv_pkg::ST_OVF);
                    end else begin
                        size_acc = size_acc + sz + 64'(pngv_pkg::CHUNK_EXTRA);
                        if (tag_word == pngv_pkg::TAG_IEND) begin
                            close_file(pngv_pkg::ST_OK);
                        end else begin
                            skip_left = 33'(sz + 64'(pngv_pkg::CRC_BYTES));
                            ph        = pngv_pkg::PH_SKIP;
                        end
                    end
                end else begin
                    byte_cnt++;
                end
            end
            pngv_pkg::PH_SKIP: begin
                if (skip_left != 0) skip_left--;
                if (skip_left == 0) ph = pngv_pkg::PH_HDR;
            end
            default: ;
        endcase
        // end of file: truncated unless already decided, then back to a fresh file
        if (eof_bit) begin
            if (!decided) close_file(pngv_pkg::ST_TRUNC);
            clear_parse();
        end
    endtask

    function automatic logic [63:0] field_of(input pngv_pkg::t_out_item r, input int k);
        logic [63:0] v;
        v = '0;
        case (k)
            0: v = 64'(r.status);
            1: v = 64'(r.image_width);
            2: v = 64'(r.image_height);
            3: v = 64'(r.bit_depth);
            4: v = 64'(r.color_type);
            5: v = 64'(r.interlace_mode);
            default: v = r.total_size;
        endcase
        return v;
    endfunction

    initial clear_parse();

    always @(posedge i_clk) begin : watch
        pngv_pkg::t_out_item want;
        if (!i_rst_n) begin
            clear_parse();
            expected_q.delete();
        end else begin
            // results leave via the input and output registers, so order is free
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    errs++;
                    $display("%0t: result transaction with nothing expected, status %0d",
                             $time, i_out_data.status);
                end else begin
                    want = expected_q.pop_front();
                    for (int k = 0; k < 7; k++) begin
                        if (field_of(want, k) !== field_of(i_out_data, k)) begin
                            errs++;
                            $display("%0t: %s expected %0h got %0h", $time, field_name[k],
                                     field_of(want, k), field_of(i_out_data, k));
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                parse_byte(i_in_data.byte_value, i_in_data.end_of_file);
        end
        o_pending <= expected_q.size();
    end

endmodule

// ----- test/testbench.sv -----
// Top of the PNG chunk stream validator bench: builds byte streams of whole files,
// drives them with random gaps and back-pressure, and reports the verdict.
// Depends on pngv_pkg, png_chunk_stream_validator_core and png_result_checker.
module testbench;

    localparam int unsigned SIZE_BITS   = 64;
    localparam int          RAND_BYTES  = 540;
    localparam int          MIN_FILES   = 6;
    localparam int          DRAIN       = 20;
    localparam int          CYCLE_LIMIT = 300000;
    localparam logic [31:0] TAG_IDAT    = 32'h4944_4154;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    pngv_pkg::t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    pngv_pkg::t_out_item out_data;
    int        fail_count;
    int        pending;

    int        cycle_count = 0;
    int        send_idle   = 0;
    int        recv_idle   = 0;
    int        bytes_sent  = 0;
    int        files_sent  = 0;
    int        n_directed  = 0;
    logic [7:0] png_bytes[$];

    png_chunk_stream_validator_core #(.SIZE_BITS(SIZE_BITS)) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    png_result_checker #(.SIZE_BITS(SIZE_BITS)) scoreboard (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        out_ready   <= ($urandom_range(99) >= recv_idle);
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("run stopped at cycle %0d, %0d results still outstanding", cycle_count,
                 pending);
        $display("testbench NOT OK");
        $finish;
    end

    // Called at a rising edge; returns at the edge where the byte was taken.
    task automatic push_byte(input logic [7:0] b, input logic eof_bit);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{byte_value: b, end_of_file: eof_bit};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_file();
        for (int k = 0; k < png_bytes.size(); k++)
            push_byte(png_bytes[k], k == png_bytes.size() - 1);
        bytes_sent += png_bytes.size();
        files_sent++;
        png_bytes.delete();
    endtask

    task automatic put_word(input logic [31:0] w);
        for (int k = 3; k >= 0; k--) png_bytes.push_back(w[8*k +: 8]);
    endtask

    task automatic put_sig();
        for (int k = 0; k < 8; k++) png_bytes.push_back(pngv_pkg::SIG_BYTES[k]);
    endtask

    task automatic put_head(input logic [31:0] len, input logic [31:0] tag,
                            input logic [31:0] wid, input logic [31:0] hgt,
                            input logic [7:0] depth, input logic [7:0] color,
                            input logic [7:0] comp, input logic [7:0] filt,
                            input logic [7:0] ilace);
        put_sig();
        put_word(len);
        put_word(tag);
        put_word(wid);
        put_word(hgt);
        png_bytes.push_back(depth);
        png_bytes.push_back(color);
        png_bytes.push_back(comp);
        png_bytes.push_back(filt);
        png_bytes.push_back(ilace);
        put_word($urandom);  // CRC, never looked at
    endtask

    task automatic put_good_head();
        logic [7:0]  depths [5] = '{8'd1, 8'd2, 8'd4, 8'd8, 8'd16};
        logic [7:0]  colors [5] = '{8'd0, 8'd2, 8'd3, 8'd4, 8'd6};
        logic [31:0] wid;
        logic [31:0] hgt;
        wid = ($urandom_range(3) == 0) ? $urandom_range(64) : ($urandom & 32'h7FFF_FFFF);
        hgt = ($urandom_range(3) == 0) ? $urandom_range(64) : ($urandom & 32'h7FFF_FFFF);
        put_head(pngv_pkg::IHDR_LEN, pngv_pkg::TAG_IHDR, wid, hgt, depths[$urandom_range(4)],
                 colors[$urandom_range(4)], 8'd0, 8'd0, 8'($urandom_range(1)));
    endtask

    task automatic put_chunk(input logic [31:0] len, input logic [31:0] tag, input int body);
        put_word(len);
        put_word(tag);
        repeat (body) png_bytes.push_back(8'($urandom));
    endtask

    function automatic logic [7:0] rand_letter();
        return 8'(($urandom_range(1) ? 8'h61 : 8'h41) + $urandom_range(25));
    endfunction

    function automatic logic [31:0] rand_tag();
        return {rand_letter(), rand_letter(), rand_letter(), rand_letter()};
    endfunction

    initial begin : stimulus
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send_idle = 24;
        recv_idle = 71;

        // directed files, one special case each
        put_head(pngv_pkg::IHDR_LEN, pngv_pkg::TAG_IHDR, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 16, 6, 0, 0, 1);
        put_chunk(0, pngv_pkg::TAG_IEND, 0);
        send_file();
        // boundary letters in a tag, zero and small bodies, IEND body ignored
        put_head(pngv_pkg::IHDR_LEN, pngv_pkg::TAG_IHDR, 0, 0, 1, 0, 0, 0, 0);
        put_chunk(0, 32'h7A61_5A41, 4);
        put_chunk(5, TAG_IDAT, 9);
        put_chunk(0, pngv_pkg::TAG_IEND, 4);
        send_file();
        // last signature byte wrong, junk until the end
        put_good_head();
        png_bytes[7] = 8'h0B;
        send_file();
        // wrong signature byte but the file ends inside the signature
        png_bytes = {8'h00, 8'h50, 8'h4E};
        send_file();
        png_bytes = {8'hFF};
        send_file();
        put_head(12, pngv_pkg::TAG_IHDR, 1, 1, 8, 2, 0, 0, 0); send_file();
        put_head(pngv_pkg::IHDR_LEN, 32'h4948_4472, 1, 1, 8, 2, 0, 0, 0); send_file();
        put_head(pngv_pkg::IHDR_LEN, pngv_pkg::TAG_IHDR, 32'h8000_0000, 1, 8, 2, 0, 0, 0);
        send_file();
        put_head(pngv_pkg::IHDR_LEN, pngv_pkg::TAG_IHDR, 1, 32'hFFFF_FFFF, 8, 2, 0, 0, 0);
        send_file();
        put_head(pngv_pkg::IHDR_LEN, pngv_pkg::TAG_IHDR, 1, 1, 0, 2, 0, 0, 0);   send_file();
        put_head(pngv_pkg::IHDR_LEN, pngv_pkg::TAG_IHDR, 1, 1, 3, 2, 0, 0, 0);   send_file();
        put_head(pngv_pkg::IHDR_LEN, pngv_pkg::TAG_IHDR, 1, 1, 255, 2, 0, 0, 0); send_file();
        put_head(pngv_pkg::IHDR_LEN, pngv_pkg::TAG_IHDR, 1, 1, 8, 1, 0, 0, 0);   send_file();
        put_head(pngv_pkg::IHDR_LEN, pngv_pkg::TAG_IHDR, 1, 1, 8, 7, 0, 0, 0);   send_file();
        put_head(pngv_pkg::IHDR_LEN, pngv_pkg::TAG_IHDR, 1, 1, 8, 2, 1, 0, 0);   send_file();
        put_head(pngv_pkg::IHDR_LEN, pngv_pkg::TAG_IHDR, 1, 1, 8, 2, 0, 8'h80, 0);
        send_file();
        put_head(pngv_pkg::IHDR_LEN, pngv_pkg::TAG_IHDR, 1, 1, 8, 2, 0, 0, 2);   send_file();
        put_head(pngv_pkg::IHDR_LEN, pngv_pkg::TAG_IHDR, 1, 1, 8, 2, 0, 0, 255); send_file();
        // cut inside the IHDR
        put_good_head();
        repeat (5) void'(png_bytes.pop_back());
        send_file();
        // ends on the last IHDR byte: nothing decided yet
        put_good_head();
        send_file();
        // characters just outside the letter ranges, one position each
        put_good_head(); put_chunk(0, 32'h4041_4141, 0); send_file();
        put_good_head(); put_chunk(0, 32'h415B_4141, 0); send_file();
        put_good_head(); put_chunk(0, 32'h4141_6041, 0); send_file();
        put_good_head(); put_chunk(0, 32'h4141_417B, 0); send_file();
        // cut inside a chunk header, inside a body, and at the end of a body
        put_good_head(); put_chunk(0, TAG_IDAT, 0);
        repeat (3) void'(png_bytes.pop_back());
        send_file();
        put_good_head(); put_chunk(10, TAG_IDAT, 6); send_file();
        put_good_head(); put_chunk(32'hFFFF_FFFF, TAG_IDAT, 3); send_file();
        put_good_head(); put_chunk(2, TAG_IDAT, 6); send_file();
        // IEND with a length counts toward the size without a body
        put_good_head(); put_chunk(7, pngv_pkg::TAG_IEND, 0); send_file();
        n_directed = files_sent;

        for (int regime = 0; regime < 3; regime++) begin : random_part
            int start_bytes;
            int start_files;
            send_idle   = (regime == 0) ? 24 : (regime == 1) ? 71 : 0;
            recv_idle   = (regime == 0) ? 71 : (regime == 1) ? 24 : 0;
            start_bytes = bytes_sent;
            start_files = files_sent;
            while (bytes_sent - start_bytes < RAND_BYTES / 3 ||
                   files_sent - start_files < MIN_FILES / 3) begin : one_file
                int  kind;
                int  len;
                int  pos;
                bit  open_body;
                kind      = $urandom_range(99);
                open_body = 1'b0;
                if (kind < 15) begin
                    // noise, sometimes behind a valid signature
                    if ($urandom_range(1)) put_sig();
                    repeat ($urandom_range(40, 1)) png_bytes.push_back(8'($urandom));
                end else begin
                    put_good_head();
                    repeat ($urandom_range(4)) begin
                        if ($urandom_range(19) == 0) begin
                            // huge length, file ends inside the body
                            put_chunk($urandom, rand_tag(), $urandom_range(8));
                            open_body = 1'b1;
                            break;
                        end
                        len = $urandom_range(24);
                        put_chunk(len, rand_tag(), len + pngv_pkg::CRC_BYTES);
                    end
                    if (!open_body) begin
                        len = ($urandom_range(3) == 0) ? $urandom_range(10, 1) : 0;
                        put_chunk(len, pngv_pkg::TAG_IEND,
                                  ($urandom_range(3) == 0) ? len + 4 : 0);
                    end
                    if (kind < 40) begin
                        // one damaged byte, biased towards the signature and IHDR
                        pos = $urandom_range(1) ? $urandom_range(pngv_pkg::HEAD_SIZE - 1)
                                                : $urandom_range(png_bytes.size() - 1);
                        png_bytes[pos] = 8'($urandom);
                        repeat ($urandom_range(6)) png_bytes.push_back(8'($urandom));
                    end else if (kind < 52) begin
                        len = $urandom_range(png_bytes.size() - 1, 1);
                        while (png_bytes.size() > len) void'(png_bytes.pop_back());
                    end
                end
                send_file();
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("%0d files, %0d bytes: %0d directed cases, the rest random valid, damaged,",
                 files_sent, bytes_sent, n_directed);
        $display("cut and noise files under three gap/back-pressure mixes, %0d mismatches",
                 fail_count);
        if (fail_count == 0 && pending == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
sv/pngv_pkg.sv
sv/pngv_parser.sv
sv/png_chunk_stream_validator_core.sv
sv/pngv_checker.sv
test/png_result_checker.sv
test/testbench.sv
